// File: design/pdq_pkg.sv
// ----------------------------------------------------------------------------
// pdq_pkg
// Shared types for the pair deque: operation codes and request/result layouts.
// ----------------------------------------------------------------------------
package pdq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_QUERY      = 3'd5
  } op_e;

  typedef struct packed {
    logic [31:0] first_value;
    logic [31:0] second_value;
  } pair_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] first_value;
    logic [31:0] second_value;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] front_first;
    logic [31:0] front_second;
    logic [31:0] back_first;
    logic [31:0] back_second;
    logic [4:0]  occupancy;
    logic        is_empty;
    logic        is_full;
  } rsp_t;

endpackage

// File: design/pair_deque_with_match_remove.sv
// ----------------------------------------------------------------------------
// pair_deque_with_match_remove
// Double-ended queue of value pairs with search-and-delete.
// ----------------------------------------------------------------------------
// The pairs live in a circular buffer in one memory, addressed through a head
// pointer and a count. A request is taken when start is high and busy is low;
// its result appears on rsp_o for one cycle with valid_o, and the receiver
// cannot stall it. Push, pop and query go through update, front/back read
// and capture. Remove scans from the front, reading and then comparing each
// entry, and then moves each later entry down with a read and a write per
// entry; the scan and the move both use read port A of the memory, which
// has two registered read ports.
module pair_deque_with_match_remove #(
  parameter int CAPACITY = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  pdq_pkg::req_t  req_i,
  output logic           valid_o,
  output pdq_pkg::rsp_t  rsp_o
);
  import pdq_pkg::*;

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SRCH_RD, ST_SRCH_CMP, ST_SH_RD, ST_SH_WR, ST_READ, ST_RESP
  } state_e;

  state_e        state_q;
  logic [PW-1:0] head_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] idx_q;
  logic          ok_q;
  pair_t         key_q;
  rsp_t          rsp_q;
  logic          valid_q;

  logic          we;
  logic [PW-1:0] waddr;
  pair_t         wdata;
  logic [PW-1:0] raddr_a;
  logic [PW-1:0] raddr_b;
  pair_t         rdata_a;
  pair_t         rdata_b;
  logic          full;
  logic          empty;
  logic [PW-1:0] head_m1;
  logic [PW-1:0] head_p1;
  logic [CW:0]   idx_p1;
  logic [CW:0]   idx_p2;

  function automatic logic [PW-1:0] phys(input logic [PW-1:0] head,
                                         input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(pos);
    if (sum >= (CW+1)'(CAPACITY)) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[PW-1:0];
  endfunction

  assign full    = (cnt_q == CW'(CAPACITY));
  assign empty   = (cnt_q == '0);
  assign head_m1 = (head_q == '0) ? PW'(CAPACITY - 1) : head_q - PW'(1);
  assign head_p1 = (head_q == PW'(CAPACITY - 1)) ? '0 : head_q + PW'(1);
  assign idx_p1  = (CW+1)'(idx_q) + (CW+1)'(1);
  assign idx_p2  = (CW+1)'(idx_q) + (CW+1)'(2);

  always_comb begin
    we      = 1'b0;
    waddr   = phys(head_q, cnt_q);
    wdata   = pair_t'{req_i.first_value, req_i.second_value};
    raddr_a = phys(head_q, idx_q);
    raddr_b = phys(head_q, cnt_q - CW'(1));
    case (state_q)
      ST_IDLE: begin
        if (start && !full) begin
          if (req_i.operation == OP_PUSH_FRONT) begin
            we    = 1'b1;
            waddr = head_m1;
          end else if (req_i.operation == OP_PUSH_BACK) begin
            we = 1'b1;
          end
        end
      end
      ST_SH_RD: raddr_a = phys(head_q, idx_p1[CW-1:0]);
      ST_SH_WR: begin
        we    = 1'b1;
        waddr = phys(head_q, idx_q);
        wdata = rdata_a;
      end
      ST_READ:  raddr_a = head_q;
      default: ;
    endcase
  end

  pdq_ram #(.Depth(CAPACITY), .Aw(PW)) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      ok_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= (state_q == ST_RESP);
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= (req_i.operation == OP_REMOVE && !empty) ? ST_SRCH_RD : ST_READ;
            case (req_i.operation)
              OP_PUSH_FRONT: begin
                ok_q <= !full;
                if (!full) begin
                  head_q <= head_m1;
                  cnt_q  <= cnt_q + CW'(1);
                end
              end
              OP_PUSH_BACK: begin
                ok_q <= !full;
                if (!full) begin
                  cnt_q <= cnt_q + CW'(1);
                end
              end
              OP_POP_FRONT: begin
                ok_q <= !empty;
                if (!empty) begin
                  head_q <= head_p1;
                  cnt_q  <= cnt_q - CW'(1);
                end
              end
              OP_POP_BACK: begin
                ok_q <= !empty;
                if (!empty) begin
                  cnt_q <= cnt_q - CW'(1);
                end
              end
              OP_REMOVE: begin
                ok_q  <= 1'b0;
                key_q <= pair_t'{req_i.first_value, req_i.second_value};
                idx_q <= '0;
              end
              OP_QUERY: ok_q <= 1'b1;
              default: ok_q <= 1'b0;
            endcase
          end
        end
        ST_SRCH_RD: state_q <= ST_SRCH_CMP;
        ST_SRCH_CMP: begin
          if (rdata_a == key_q) begin
            if (idx_p1 < (CW+1)'(cnt_q)) begin
              state_q <= ST_SH_RD;
            end else begin
              cnt_q   <= cnt_q - CW'(1);
              ok_q    <= 1'b1;
              state_q <= ST_READ;
            end
          end else if (idx_p1 < (CW+1)'(cnt_q)) begin
            idx_q   <= idx_p1[CW-1:0];
            state_q <= ST_SRCH_RD;
          end else begin
            state_q <= ST_READ;
          end
        end
        ST_SH_RD: state_q <= ST_SH_WR;
        ST_SH_WR: begin
          // The entry above was just copied down; continue while another remains.
          idx_q <= idx_p1[CW-1:0];
          if (idx_p2 < (CW+1)'(cnt_q)) begin
            state_q <= ST_SH_RD;
          end else begin
            cnt_q   <= cnt_q - CW'(1);
            ok_q    <= 1'b1;
            state_q <= ST_READ;
          end
        end
        ST_READ: state_q <= ST_RESP;
        ST_RESP: begin
          rsp_q.ok           <= ok_q;
          rsp_q.front_first  <= empty ? '0 : rdata_a.first_value;
          rsp_q.front_second <= empty ? '0 : rdata_a.second_value;
          rsp_q.back_first   <= empty ? '0 : rdata_b.first_value;
          rsp_q.back_second  <= empty ? '0 : rdata_b.second_value;
          rsp_q.occupancy    <= 5'(cnt_q);
          rsp_q.is_empty     <= empty;
          rsp_q.is_full      <= full;
          state_q            <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

// File: design/pdq_ram.sv
// ----------------------------------------------------------------------------
// pdq_ram
// Pair storage: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module pdq_ram #(
  parameter int Depth = 16,
  parameter int Aw    = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [Aw-1:0]   waddr_i,
  input  pdq_pkg::pair_t  wdata_i,
  input  logic [Aw-1:0]   raddr_a_i,
  input  logic [Aw-1:0]   raddr_b_i,
  output pdq_pkg::pair_t  rdata_a_o,
  output pdq_pkg::pair_t  rdata_b_o
);
  import pdq_pkg::*;

  pair_t mem [Depth];
  pair_t rdata_a_q;
  pair_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: tb/pair_deque_with_match_remove_tb.sv
// ----------------------------------------------------------------------------
// pair_deque_with_match_remove_tb
// Drives deque requests (pushes, pops, match removes, queries, unknown codes)
// against a behavioral model of the pair store and checks every result field.
// ----------------------------------------------------------------------------
module pair_deque_with_match_remove_tb;
  import pdq_pkg::*;

  localparam int CAPACITY = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  req_t  req_i = '0;
  logic  valid_o;
  rsp_t  rsp_o;

  pair_deque_with_match_remove #(.CAPACITY(CAPACITY)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .valid_o(valid_o), .rsp_o(rsp_o)
  );

  always #10 clk_i = ~clk_i;

  // Behavioral copy of the pair store.
  logic [31:0] store_first [CAPACITY];
  logic [31:0] store_second[CAPACITY];
  int          held;

  rsp_t pending_results[$];
  int   error_count = 0;
  int   request_count = 0;
  int   result_count = 0;
  int   removes_hit = 0;
  int   full_refusals = 0;
  int   idle_cycles = 0;
  int   sender_idle_pct = 30;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h (result %0d)",
             what, got, want, result_count);
    error_count++;
  endtask

  function automatic rsp_t apply_request(input req_t r);
    rsp_t o;
    logic ok;
    int hit;
    o = '0;
    ok = 1'b0;
    hit = -1;
    case (r.operation)
      OP_PUSH_FRONT: if (held < CAPACITY) begin
        for (int i = held; i > 0; i--) begin
          store_first[i]  = store_first[i-1];
          store_second[i] = store_second[i-1];
        end
        store_first[0]  = r.first_value;
        store_second[0] = r.second_value;
        held++;
        ok = 1'b1;
      end
      OP_PUSH_BACK: if (held < CAPACITY) begin
        store_first[held]  = r.first_value;
        store_second[held] = r.second_value;
        held++;
        ok = 1'b1;
      end
      OP_POP_FRONT: if (held > 0) begin
        for (int i = 0; i + 1 < held; i++) begin
          store_first[i]  = store_first[i+1];
          store_second[i] = store_second[i+1];
        end
        held--;
        ok = 1'b1;
      end
      OP_POP_BACK: if (held > 0) begin
        held--;
        ok = 1'b1;
      end
      OP_REMOVE: begin
        for (int i = 0; i < held; i++)
          if (hit < 0 && store_first[i] == r.first_value &&
              store_second[i] == r.second_value)
            hit = i;
        if (hit >= 0) begin
          for (int i = hit; i + 1 < held; i++) begin
            store_first[i]  = store_first[i+1];
            store_second[i] = store_second[i+1];
          end
          held--;
          ok = 1'b1;
          removes_hit++;
        end
      end
      OP_QUERY: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    o.ok = ok;
    if (held > 0) begin
      o.front_first  = store_first[0];
      o.front_second = store_second[0];
      o.back_first   = store_first[held-1];
      o.back_second  = store_second[held-1];
    end
    o.occupancy = held[4:0];
    o.is_empty  = (held == 0);
    o.is_full   = (held == CAPACITY);
    return o;
  endfunction

  // Start stays high from one request to the next unless the sender idles;
  // it is only dropped while idling or draining.
  task automatic send_request(input logic [2:0] op, input logic [31:0] a,
                              input logic [31:0] b);
    req_t r;
    r.operation = op;
    r.first_value = a;
    r.second_value = b;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (r.operation inside {OP_PUSH_FRONT, OP_PUSH_BACK} && held == CAPACITY)
      full_refusals++;
    pending_results.push_back(apply_request(r));
    request_count++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      rsp_t want;
      result_count++;
      if (pending_results.size() == 0) begin
        $display("unexpected result %0d", result_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_o.ok !== want.ok) report_mismatch("ok", rsp_o.ok, want.ok);
        if (rsp_o.front_first !== want.front_first)
          report_mismatch("front_first", rsp_o.front_first, want.front_first);
        if (rsp_o.front_second !== want.front_second)
          report_mismatch("front_second", rsp_o.front_second, want.front_second);
        if (rsp_o.back_first !== want.back_first)
          report_mismatch("back_first", rsp_o.back_first, want.back_first);
        if (rsp_o.back_second !== want.back_second)
          report_mismatch("back_second", rsp_o.back_second, want.back_second);
        if (rsp_o.occupancy !== want.occupancy)
          report_mismatch("occupancy", rsp_o.occupancy, want.occupancy);
        if (rsp_o.is_empty !== want.is_empty)
          report_mismatch("is_empty", rsp_o.is_empty, want.is_empty);
        if (rsp_o.is_full !== want.is_full)
          report_mismatch("is_full", rsp_o.is_full, want.is_full);
      end
    end
  end

  // Watchdog on cycles with neither a request nor a result accepted.
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(OP_QUERY, 32'h0, 32'h0);
    send_request(OP_POP_FRONT, 32'h0, 32'h0);
    send_request(OP_POP_BACK, 32'h0, 32'h0);
    send_request(OP_REMOVE, 32'h0, 32'h0);
    send_request(OP_PUSH_BACK, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(OP_PUSH_FRONT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_PUSH_BACK, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(OP_PUSH_BACK, 32'h0, 32'h0);
    send_request(3'd6, 32'h1, 32'h2);
    send_request(3'd7, 32'h1, 32'h2);
    // Partial match on one value only must not remove anything.
    send_request(OP_REMOVE, 32'h7FFF_FFFF, 32'h0);
    send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(OP_POP_FRONT, 32'h0, 32'h0);
    send_request(OP_POP_BACK, 32'h0, 32'h0);
    // Fill to capacity, then refused pushes at both ends.
    while (held < CAPACITY) send_request(OP_PUSH_BACK, $urandom, $urandom);
    send_request(OP_PUSH_FRONT, 32'h5, 32'h5);
    send_request(OP_PUSH_BACK, 32'h5, 32'h5);
    send_request(OP_REMOVE, store_first[CAPACITY-1], store_second[CAPACITY-1]);
    wait_drained();
  endtask

  // Small value pool so that removes hit often, including duplicates.
  task automatic test_random(input int count);
    logic [31:0] a, b;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if ($urandom_range(3) == 0) begin
        a = $urandom;
        b = $urandom;
      end else begin
        a = $urandom_range(3);
        b = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      end
      if (held > 0 && $urandom_range(1)) begin
        int k = $urandom_range(held - 1);
        a = store_first[k];
        b = store_second[k];
      end
      if (pick < 22) send_request(OP_PUSH_FRONT, a, b);
      else if (pick < 44) send_request(OP_PUSH_BACK, a, b);
      else if (pick < 56) send_request(OP_POP_FRONT, a, b);
      else if (pick < 68) send_request(OP_POP_BACK, a, b);
      else if (pick < 90) send_request(OP_REMOVE, a, b);
      else if (pick < 96) send_request(OP_QUERY, a, b);
      else send_request(3'($urandom_range(6, 7)), a, b);
    end
  endtask

  initial begin
    held = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    sender_idle_pct = 30;
    test_random(260);
    wait_drained();
    sender_idle_pct = 60;
    test_random(260);
    sender_idle_pct = 0;
    test_random(260);
    wait_drained();
    repeat (4 * CAPACITY + 10) @(posedge clk_i);
    $display("Covered %0d requests and %0d results: %0d removes found a match,",
             request_count, result_count, removes_hit);
    $display("%0d pushes refused when full, unknown codes and empty pops included.",
             full_refusals);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
